// File: rtl/core/pplt_pkg.sv
// ----------------------------------------------------------------------------
// pplt_pkg
// Shared widths, command/status types for the path position and length tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pplt_pkg;

  // Field widths
  localparam int STEP_BITS = 16;
  localparam int POS_BITS  = 24;
  localparam int FRAC_BITS = 8;
  localparam int LEN_BITS  = 40;
  localparam int DISP_BITS = 32;

  // Square root unit: radicand holds x^2 + y^2 of a position
  localparam int RAD_BITS  = 2 * POS_BITS;
  localparam int ROOT_BITS = RAD_BITS / 2 + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(ROOT_BITS);

  // Stream widths
  localparam int IN_TDATA_W  = 2 * STEP_BITS;
  localparam int OUT_TDATA_W = 2 * POS_BITS + DISP_BITS + LEN_BITS;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take input request, update position
    logic square;   // register the four squares
    logic sum;      // add squares, seed both root units
    logic iterate;  // one root bit per cycle
    logic finish;   // accumulate length, load output register
  } pplt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } pplt_status_t;

endpackage

`default_nettype wire

// File: rtl/core/path_position_and_length_tracker.sv
// ----------------------------------------------------------------------------
// path_position_and_length_tracker
// Tracks the end position and total length of a path built from 2-D steps.
// ----------------------------------------------------------------------------
// Each input request is one signed step; start_new_path clears position and
// length first. Every step yields one result: the saturated end position, its
// distance from the origin and the running path length, both unsigned Q.8
// (floor of sqrt times 256), plus a flag for position or length saturation.
// One request is in work at a time, from the accepting cycle until its result
// is in the output register: one load, one squaring, one radicand add, one
// iteration per root bit of the two bit-serial square root units running side
// by side, and one accumulate. The accumulate waits while the output register
// still holds a result that has not been taken, so an output stall there holds
// the request back. The next request is taken in the cycle after the result is
// loaded.
`default_nettype none

module path_position_and_length_tracker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [pplt_pkg::IN_TDATA_W-1:0]      in_tdata,  // step_x, step_y
  input  wire logic [0:0]                           in_tuser,  // start_new_path
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // end_x, end_y, displacement, path_length
  output logic      [pplt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic      [0:0]                           out_tuser  // saturated
);
  import pplt_pkg::*;

  pplt_cmd_t    cmd;
  pplt_status_t status;

  logic signed [STEP_BITS-1:0] step_x, step_y;
  logic signed [POS_BITS-1:0]  end_x, end_y;
  logic [DISP_BITS-1:0]        displacement;
  logic [LEN_BITS-1:0]         path_length;
  logic                        saturated;

  assign step_x = in_tdata[STEP_BITS-1:0];
  assign step_y = in_tdata[2*STEP_BITS-1:STEP_BITS];

  pplt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pplt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .start_new_path (in_tuser[0]),
    .step_x         (step_x),
    .step_y         (step_y),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .end_x          (end_x),
    .end_y          (end_y),
    .displacement   (displacement),
    .path_length    (path_length),
    .saturated      (saturated)
  );

  assign out_tdata = {path_length, displacement, end_y, end_x};
  assign out_tuser = saturated;

endmodule

`default_nettype wire

// File: rtl/core/pplt_sqrt.sv
// ----------------------------------------------------------------------------
// pplt_sqrt
// Bit-serial integer square root: floor(sqrt(rad) * 2^FRAC_BITS), one bit/cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pplt_sqrt (
  input  wire logic                           clk,
  input  wire logic                           start,
  input  wire logic                           step,
  input  wire logic [pplt_pkg::RAD_BITS-1:0]  rad,
  output logic      [pplt_pkg::ROOT_BITS-1:0] root
);
  import pplt_pkg::*;

  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int CMP_BITS = REM_BITS + 2;

  logic [RAD_BITS-1:0]  rad_sh_r, rad_sh_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic [CMP_BITS-1:0]  rem_sh;
  logic [CMP_BITS-1:0]  trial;

  // One digit: bring down the next bit pair, try (root << 2) | 1
  always_comb begin
    rem_sh     = {rem_r, rad_sh_r[RAD_BITS-1 -: 2]};
    trial      = {2'b00, root_r, 2'b01};
    rad_sh_nxt = {rad_sh_r[RAD_BITS-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = REM_BITS'(rem_sh - trial);
      root_nxt = {root_r[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[REM_BITS-1:0];
      root_nxt = {root_r[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh_r <= rad;
      root_r   <= '0;
      rem_r    <= '0;
    end else if (step) begin
      rad_sh_r <= rad_sh_nxt;
      root_r   <= root_nxt;
      rem_r    <= rem_nxt;
    end
  end

  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/core/pplt_datapath.sv
// ----------------------------------------------------------------------------
// pplt_datapath
// Position/length state, squaring, two root units and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pplt_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pplt_pkg::pplt_cmd_t                 cmd,
  output pplt_pkg::pplt_status_t                   status,
  input  wire logic                                start_new_path,
  input  wire logic signed [pplt_pkg::STEP_BITS-1:0] step_x,
  input  wire logic signed [pplt_pkg::STEP_BITS-1:0] step_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pplt_pkg::POS_BITS-1:0]     end_x,
  output logic signed [pplt_pkg::POS_BITS-1:0]     end_y,
  output logic        [pplt_pkg::DISP_BITS-1:0]    displacement,
  output logic        [pplt_pkg::LEN_BITS-1:0]     path_length,
  output logic                                     saturated
);
  import pplt_pkg::*;

  localparam int SUM_BITS  = POS_BITS + 1;
  localparam int SSQ_BITS  = 2 * STEP_BITS;
  localparam int LSUM_BITS = LEN_BITS + 1;

  // Path state
  logic signed [POS_BITS-1:0]  pos_x_r, pos_y_r;
  logic        [LEN_BITS-1:0]  total_r;
  logic signed [STEP_BITS-1:0] sx_r, sy_r;
  logic                        sat_r;

  // Squares
  logic [RAD_BITS-1:0] sq_px_r, sq_py_r;
  logic [SSQ_BITS-1:0] sq_sx_r, sq_sy_r;

  // Output register
  logic                       out_valid_r;
  logic signed [POS_BITS-1:0] end_x_r, end_y_r;
  logic [DISP_BITS-1:0]       disp_r;
  logic [LEN_BITS-1:0]        len_r;
  logic                       out_sat_r;

  logic signed [POS_BITS-1:0] base_x, base_y, clamp_x, clamp_y;
  logic signed [SUM_BITS-1:0] sum_x, sum_y;
  logic                       ovf_x, ovf_y;
  logic [POS_BITS-1:0]        mag_px, mag_py;
  logic [STEP_BITS-1:0]       mag_sx, mag_sy;
  logic [RAD_BITS-1:0]        rad_disp, rad_step;
  logic [ROOT_BITS-1:0]       root_disp, root_step;
  logic [LSUM_BITS-1:0]       len_sum;

  // Signed saturation of a one-bit-wider sum
  function automatic logic signed [POS_BITS-1:0] clamp_pos(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [POS_BITS-1:0] res;
    if (v[SUM_BITS-1] != v[SUM_BITS-2]) begin
      res = v[SUM_BITS-1] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      res = v[POS_BITS-1:0];
    end
    return res;
  endfunction

  // New position, with optional clear of the path
  always_comb begin
    base_x  = start_new_path ? '0 : pos_x_r;
    base_y  = start_new_path ? '0 : pos_y_r;
    sum_x   = SUM_BITS'(base_x) + SUM_BITS'(step_x);
    sum_y   = SUM_BITS'(base_y) + SUM_BITS'(step_y);
    ovf_x   = sum_x[SUM_BITS-1] != sum_x[SUM_BITS-2];
    ovf_y   = sum_y[SUM_BITS-1] != sum_y[SUM_BITS-2];
    clamp_x = clamp_pos(sum_x);
    clamp_y = clamp_pos(sum_y);
  end

  // Magnitudes for squaring
  always_comb begin
    mag_px = pos_x_r[POS_BITS-1] ? POS_BITS'(-pos_x_r) : POS_BITS'(pos_x_r);
    mag_py = pos_y_r[POS_BITS-1] ? POS_BITS'(-pos_y_r) : POS_BITS'(pos_y_r);
    mag_sx = sx_r[STEP_BITS-1] ? STEP_BITS'(-sx_r) : STEP_BITS'(sx_r);
    mag_sy = sy_r[STEP_BITS-1] ? STEP_BITS'(-sy_r) : STEP_BITS'(sy_r);
  end

  // Radicands, added on the way into the root units
  assign rad_disp = sq_px_r + sq_py_r;
  assign rad_step = RAD_BITS'(sq_sx_r) + RAD_BITS'(sq_sy_r);

  pplt_sqrt u_sqrt_disp (
    .clk   (clk),
    .start (cmd.sum),
    .step  (cmd.iterate),
    .rad   (rad_disp),
    .root  (root_disp)
  );

  pplt_sqrt u_sqrt_step (
    .clk   (clk),
    .start (cmd.sum),
    .step  (cmd.iterate),
    .rad   (rad_step),
    .root  (root_step)
  );

  // Saturating length accumulate
  assign len_sum = LSUM_BITS'(total_r) + LSUM_BITS'(root_step);

  // Path state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      total_r <= '0;
    end else if (cmd.load) begin
      pos_x_r <= clamp_x;
      pos_y_r <= clamp_y;
      if (start_new_path) begin
        total_r <= '0;
      end
    end else if (cmd.finish) begin
      total_r <= len_sum[LSUM_BITS-1] ? '1 : len_sum[LEN_BITS-1:0];
    end
  end

  // Step capture and squares
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r  <= step_x;
      sy_r  <= step_y;
      sat_r <= ovf_x | ovf_y;
    end
    if (cmd.square) begin
      sq_px_r <= RAD_BITS'(mag_px * mag_px);
      sq_py_r <= RAD_BITS'(mag_py * mag_py);
      sq_sx_r <= SSQ_BITS'(mag_sx * mag_sx);
      sq_sy_r <= SSQ_BITS'(mag_sy * mag_sy);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      end_x_r   <= pos_x_r;
      end_y_r   <= pos_y_r;
      disp_r    <= DISP_BITS'(root_disp);
      len_r     <= len_sum[LSUM_BITS-1] ? '1 : len_sum[LEN_BITS-1:0];
      out_sat_r <= sat_r | len_sum[LSUM_BITS-1];
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign end_x           = end_x_r;
  assign end_y           = end_y_r;
  assign displacement    = disp_r;
  assign path_length     = len_r;
  assign saturated       = out_sat_r;

endmodule

`default_nettype wire

// File: rtl/core/pplt_ctrl.sv
// ----------------------------------------------------------------------------
// pplt_ctrl
// Sequencer: load, square, seed roots, iterate, then hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pplt_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output pplt_pkg::pplt_cmd_t         cmd,
  input  wire pplt_pkg::pplt_status_t status
);
  import pplt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROOT_BITS - 1);

  logic [2:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.iterate = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SQUARE))
    else $error("accepted request did not start the sequence");

  a_root_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && cnt_r == CNT_LAST) |=> (state_r == S_DONE))
    else $error("root iteration count wrong");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

// File: test/tb_path_position_and_length_tracker.sv
// ----------------------------------------------------------------------------
// tb_path_position_and_length_tracker
// Self-checking stream testbench for the path position and length tracker.
// ----------------------------------------------------------------------------
// A queue of step requests, filled up front, feeds a clocked driver. Each
// request accepted by the block runs through a local path tracker that
// predicts position, displacement, path length and saturation. A clocked
// monitor checks every result against the oldest prediction. Both sides
// stall at random, except during a quiet window. The stimulus is a short
// directed list, then two long straight runs that drive both axes into
// saturation at all four limits, then random paths.
// ----------------------------------------------------------------------------

module tb_path_position_and_length_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import pplt_pkg::*;

  localparam longint unsigned LEN_MAX  = (64'd1 << LEN_BITS) - 64'd1;
  localparam longint unsigned DISP_MAX = 64'hFFFF_FFFF;
  localparam longint          POS_HI   = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
  localparam longint          POS_LO   = -POS_HI - 64'sd1;
  localparam int QUIET_FROM   = 9000;   // cycle window with no stalls
  localparam int QUIET_TO     = 15000;
  localparam int STALL_PCT    = 37;
  localparam int WATCHDOG_MAX = 3000;
  localparam int TAIL_CYCLES  = 50;
  localparam int PRINT_MAX    = 30;

  typedef struct {
    bit                    start;
    logic [STEP_BITS-1:0]  sx;
    logic [STEP_BITS-1:0]  sy;
  } step_req_t;

  typedef struct {
    logic [POS_BITS-1:0]   end_x;
    logic [POS_BITS-1:0]   end_y;
    logic [DISP_BITS-1:0]  disp;
    logic [LEN_BITS-1:0]   len;
    logic                  sat;
  } track_result_t;

  // DUT signals, all inputs known from time zero
  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;  // step_x, step_y
  logic [0:0]              in_tuser   = '0;  // start_new_path
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;        // end_x, end_y, displacement, path_length
  logic [0:0]              out_tuser;        // saturated

  path_position_and_length_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Queues and counters
  step_req_t      step_queue[$];
  track_result_t  expected_tracks[$];
  int             cyc_count     = 0;
  int             idle_cycles   = 0;
  int             mismatches    = 0;
  int             steps_taken   = 0;
  int             paths_started = 0;
  int             tracks_seen   = 0;
  int             sat_seen      = 0;

  // Local copy of the tracker state
  longint           path_x   = 0;
  longint           path_y   = 0;
  longint unsigned  path_len = 0;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(sqrt(rad) * 2^FRAC_BITS), digit by digit
  function automatic longint unsigned fixed_root(longint unsigned rad);
    longint unsigned root = 0;
    longint unsigned rem  = 0;
    longint unsigned pair;
    longint unsigned trial;
    for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
      pair = (i >= FRAC_BITS) ? ((rad >> (2 * (i - FRAC_BITS))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned square_sum(longint a, longint b);
    longint unsigned ua = (a < 0) ? -a : a;
    longint unsigned ub = (b < 0) ? -b : b;
    return ua * ua + ub * ub;
  endfunction

  function automatic longint clamp_axis(longint v, inout bit sat);
    if (v > POS_HI) begin
      sat = 1'b1;
      return POS_HI;
    end
    if (v < POS_LO) begin
      sat = 1'b1;
      return POS_LO;
    end
    return v;
  endfunction

  // Advance the local path by one step and form the expected result
  function automatic track_result_t track_step(bit start, logic signed [STEP_BITS-1:0] sx,
                                               logic signed [STEP_BITS-1:0] sy);
    track_result_t    r;
    longint unsigned  step_len;
    longint unsigned  disp;
    bit               sat = 1'b0;
    if (start) begin
      path_x   = 0;
      path_y   = 0;
      path_len = 0;
    end
    step_len = fixed_root(square_sum(longint'(sx), longint'(sy)));
    if (step_len > LEN_MAX - path_len) begin
      path_len = LEN_MAX;
      sat = 1'b1;
    end else begin
      path_len += step_len;
    end
    path_x = clamp_axis(path_x + longint'(sx), sat);
    path_y = clamp_axis(path_y + longint'(sy), sat);
    disp = fixed_root(square_sum(path_x, path_y));
    if (disp > DISP_MAX) disp = DISP_MAX;
    r.end_x = path_x[POS_BITS-1:0];
    r.end_y = path_y[POS_BITS-1:0];
    r.disp  = disp[DISP_BITS-1:0];
    r.len   = path_len[LEN_BITS-1:0];
    r.sat   = sat;
    return r;
  endfunction

  function automatic bit take_break();
    if (cyc_count >= QUIET_FROM && cyc_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < STALL_PCT;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic add_step(bit start, int x, int y);
    step_req_t r;
    r.start = start;
    r.sx    = STEP_BITS'(x);
    r.sy    = STEP_BITS'(y);
    step_queue.push_back(r);
  endtask

  // Straight run of near-full steps, long enough to clamp both axes
  task automatic add_drift(int dir_x, int dir_y, int count);
    int mx;
    int my;
    for (int i = 0; i < count; i++) begin
      mx = 32000 + $urandom_range(767);
      my = 32000 + $urandom_range(767);
      add_step(i == 0, (dir_x > 0) ? mx : -mx - 1, (dir_y > 0) ? my : -my - 1);
    end
  endtask

  function automatic int random_coord();
    int kind = $urandom_range(9);
    int pick;
    if (kind < 4) return int'($signed(16'($urandom())));
    if (kind < 6) return int'($urandom_range(32)) - 16;
    if (kind == 6) begin
      pick = $urandom_range(3);
      case (pick)
        0: return -32768;
        1: return 32767;
        2: return -1;
        default: return 0;
      endcase
    end
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Driver: predicts on acceptance, then presents the next request
  always @(posedge clk) begin
    step_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_tracks.push_back(track_step(in_tuser[0], in_tdata[STEP_BITS-1:0],
                                             in_tdata[2*STEP_BITS-1:STEP_BITS]));
        steps_taken++;
        if (in_tuser[0]) paths_started++;
      end
      if (!in_tvalid || in_tready) begin
        if (step_queue.size() > 0 && !take_break()) begin
          r = step_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {r.sy, r.sx};
          in_tuser  <= r.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= !take_break();
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    track_result_t got;
    track_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.end_x = out_tdata[POS_BITS-1:0];
      got.end_y = out_tdata[2*POS_BITS-1:POS_BITS];
      got.disp  = out_tdata[2*POS_BITS+DISP_BITS-1:2*POS_BITS];
      got.len   = out_tdata[OUT_TDATA_W-1:2*POS_BITS+DISP_BITS];
      got.sat   = out_tuser[0];
      tracks_seen++;
      if (got.sat) sat_seen++;
      if (expected_tracks.size() == 0) begin
        flag_mismatch("unexpected result", 0, got.end_x);
      end else begin
        want = expected_tracks.pop_front();
        if (got.end_x !== want.end_x) flag_mismatch("end_x", want.end_x, got.end_x);
        if (got.end_y !== want.end_y) flag_mismatch("end_y", want.end_y, got.end_y);
        if (got.disp  !== want.disp)  flag_mismatch("displacement", want.disp, got.disp);
        if (got.len   !== want.len)   flag_mismatch("path_length", want.len, got.len);
        if (got.sat   !== want.sat)   flag_mismatch("saturated", want.sat, got.sat);
      end
    end
  end

  // Cycle count and watchdog on handshake activity
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("tb_path_position_and_length_tracker NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int run_len;
    int random_total;

    // Directed: first step from reset without start, corners, zero steps
    add_step(1'b0, 3, 4);
    add_step(1'b0, -32768, -32768);
    add_step(1'b0, 32767, 32767);
    add_step(1'b1, 32767, -32768);
    add_step(1'b0, -32768, 32767);
    add_step(1'b1, 0, 0);
    add_step(1'b0, 0, 0);
    add_step(1'b0, 1, 0);
    add_step(1'b0, 0, -1);
    add_step(1'b0, 1, 1);
    add_step(1'b0, -1, -1);
    add_step(1'b1, -32768, 0);
    add_step(1'b0, 0, 32767);
    add_step(1'b0, 12345, -6789);
    add_step(1'b1, -1, 0);
    add_step(1'b1, 1, 1);

    // Both axes into saturation, first toward +x/-y, then -x/+y
    add_drift(1, -1, 268);
    // walk back from the clamped corner without clearing
    for (int i = 0; i < 12; i++) add_step(1'b0, -32768, 32767);
    add_drift(-1, 1, 268);

    // Random paths, occasional restart in the middle
    random_total = 548;
    while (random_total < 640) begin
      run_len = 1 + $urandom_range(19);
      for (int i = 0; i < run_len; i++)
        add_step((i == 0) || ($urandom_range(19) == 0), random_coord(), random_coord());
      random_total += run_len;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (step_queue.size() > 0 || in_tvalid || expected_tracks.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_tracks.size() > 0)
      flag_mismatch("missing results", expected_tracks.size(), 0);

    $display("steps sent: %0d over %0d new paths; results checked: %0d, %0d saturated",
             steps_taken, paths_started, tracks_seen, sat_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("tb_path_position_and_length_tracker OK");
    end else begin
      $display("tb_path_position_and_length_tracker NOT OK");
    end
    $finish;
  end

endmodule
